// ===== rtl/periodic_schedule_table_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the periodic schedule table core
// Implication checks on the rising clock edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SCHEDULE_TABLE_CORE_ASSERT_SVH
`define PERIODIC_SCHEDULE_TABLE_CORE_ASSERT_SVH
`ifndef SYNTH
`define PST_ASSERT_IMPLY(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`define PST_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`else
`define PST_ASSERT_IMPLY(lbl, clk, rst, a, b, msg)
`define PST_ASSERT_NEXT(lbl, clk, rst, a, b, msg)
`endif
`endif

// ===== rtl/pst_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic schedule table package
// Shared constants, command and status types for the schedule table core.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 16;
   localparam int RESULT_COUNT_WIDTH  = 5;
   localparam int CSR_INDEX_WIDTH     = 4;
   localparam int CSR_DATA_WIDTH      = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_BASE    = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD_UNITS = 4'd1;

   localparam logic [15:0] TIME_BASE_RESET    = 16'd1;
   localparam logic [15:0] PERIOD_UNITS_RESET = 16'd0;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_START  = 2'd1,
      OP_STOP   = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RUN_STOPPED  = 2'd0,
      RUN_PERIODIC = 2'd1,
      RUN_FOREVER  = 2'd2
   } run_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_TK_TEST,
      ST_TK_CMP,
      ST_TK_END
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic [15:0] offset_units;
      logic [7:0]  action_id;
      logic [15:0] repeat_count;
   } cmd_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [7:0]  action;
   } entry_type;

   typedef struct packed {
      state_type state;
      logic      pend_valid;
   } back_status_type;

endpackage

// ===== rtl/pst_front.sv =====
// ----------------------------------------------------------------------------
// Schedule table front end
// Accepts request transfers, decodes the mode and queues commands.
// ----------------------------------------------------------------------------
module pst_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_mode,
   input  logic [31:0]      req_now_ms,
   input  logic [15:0]      req_offset_units,
   input  logic [7:0]       req_action_id,
   input  logic [15:0]      req_repeat_count,
   output logic             q_valid,
   input  logic             q_pop,
   output pst_pkg::cmd_type q_cmd
);

   localparam int QUEUE_DEPTH = 2;

   pst_pkg::cmd_type cmd_in;
   pst_pkg::cmd_type queue_ff [QUEUE_DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push;

   always_comb begin
      cmd_in = '0;
      case (req_mode)
         pst_pkg::OP_INSERT: begin
            cmd_in.op           = pst_pkg::OP_INSERT;
            cmd_in.offset_units = req_offset_units;
            cmd_in.action_id    = req_action_id;
         end
         pst_pkg::OP_START: begin
            cmd_in.op           = pst_pkg::OP_START;
            cmd_in.now_ms       = req_now_ms;
            cmd_in.repeat_count = req_repeat_count;
         end
         pst_pkg::OP_STOP: begin
            cmd_in.op = pst_pkg::OP_STOP;
         end
         pst_pkg::OP_TICK: begin
            cmd_in.op     = pst_pkg::OP_TICK;
            cmd_in.now_ms = req_now_ms;
         end
         default: begin
            cmd_in.op = pst_pkg::OP_STOP;
         end
      endcase
   end

   assign req_ready = (fill_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_cmd     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !q_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && q_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/pst_back.sv =====
// ----------------------------------------------------------------------------
// Schedule table back end
// Executes queued commands against the sorted table memory and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module pst_back #(
   parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [15:0]              time_base,
   input  logic [15:0]              period_units,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  pst_pkg::cmd_type         q_cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_fired_action,
   output logic                     rsp_last_fired,
   output pst_pkg::back_status_type status
);

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW = pst_pkg::RESULT_COUNT_WIDTH;

   pst_pkg::entry_type entry_mem [TABLE_DEPTH];
   pst_pkg::entry_type rd_data_ff;
   pst_pkg::entry_type mem_wdata;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [AW-1:0]      mem_raddr;

   pst_pkg::state_type state_ff, state_in;
   pst_pkg::run_type   run_ff, run_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      next_ff, next_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      pos_m1;
   logic [31:0]        origin_ff, origin_in;
   logic [15:0]        left_ff, left_in;
   logic [15:0]        left_dec;
   logic [31:0]        off_ff, off_in;
   logic [7:0]         id_ff, id_in;
   logic [31:0]        elapsed_ff, elapsed_in;
   logic [31:0]        per_ff;
   logic [NW-1:0]      n_ff, n_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [7:0]         pend_act_ff, pend_act_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_act_ff, rsp_act_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               slot_free;
   logic               due;
   logic               shift;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign due       = (elapsed_ff >= rd_data_ff.offset);
   assign shift     = (rd_data_ff.offset > off_ff);
   assign pos_m1    = pos_ff - CW'(1);
   assign left_dec  = left_ff - 16'd1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pst_pkg::ST_IDLE: begin
            if (q_valid) begin
               if (q_cmd.op == pst_pkg::OP_INSERT) begin
                  state_in = pst_pkg::ST_INS_CHK;
               end else if (q_cmd.op == pst_pkg::OP_TICK && run_ff != pst_pkg::RUN_STOPPED) begin
                  state_in = pst_pkg::ST_TK_TEST;
               end
            end
         end
         pst_pkg::ST_INS_CHK: begin
            if (count_ff >= CW'(TABLE_DEPTH) || off_ff > per_ff) begin
               state_in = pst_pkg::ST_IDLE;
            end else if (count_ff == '0) begin
               state_in = pst_pkg::ST_INS_PUT;
            end else begin
               state_in = pst_pkg::ST_INS_RD;
            end
         end
         pst_pkg::ST_INS_RD: begin
            state_in = pst_pkg::ST_INS_CMP;
         end
         pst_pkg::ST_INS_CMP: begin
            if (shift) begin
               state_in = (pos_m1 == '0) ? pst_pkg::ST_INS_PUT : pst_pkg::ST_INS_RD;
            end else begin
               state_in = pst_pkg::ST_IDLE;
            end
         end
         pst_pkg::ST_INS_PUT: begin
            state_in = pst_pkg::ST_IDLE;
         end
         pst_pkg::ST_TK_TEST: begin
            if (n_ff < NW'(pst_pkg::MAX_RESULTS) && next_ff < count_ff) begin
               state_in = pst_pkg::ST_TK_CMP;
            end else begin
               state_in = pst_pkg::ST_TK_END;
            end
         end
         pst_pkg::ST_TK_CMP: begin
            if (!due) begin
               state_in = pst_pkg::ST_TK_END;
            end else if (!pend_valid_ff || slot_free) begin
               state_in = pst_pkg::ST_TK_TEST;
            end
         end
         pst_pkg::ST_TK_END: begin
            if (!pend_valid_ff || slot_free) begin
               state_in = pst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pst_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      run_in        = run_ff;
      count_in      = count_ff;
      next_in       = next_ff;
      pos_in        = pos_ff;
      origin_in     = origin_ff;
      left_in       = left_ff;
      off_in        = off_ff;
      id_in         = id_ff;
      elapsed_in    = elapsed_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_act_in   = pend_act_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_act_in    = rsp_act_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff[AW-1:0];
      mem_wdata     = '{offset: off_ff, action: id_ff};
      mem_raddr     = next_ff[AW-1:0];
      case (state_ff)
         pst_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.op)
                  pst_pkg::OP_INSERT: begin
                     off_in = {16'd0, q_cmd.offset_units} * {16'd0, time_base};
                     id_in  = q_cmd.action_id;
                     pos_in = count_ff;
                  end
                  pst_pkg::OP_START: begin
                     origin_in = q_cmd.now_ms;
                     next_in   = '0;
                     left_in   = q_cmd.repeat_count;
                     run_in    = (q_cmd.repeat_count != 16'd0) ? pst_pkg::RUN_PERIODIC
                                                               : pst_pkg::RUN_FOREVER;
                  end
                  pst_pkg::OP_STOP: begin
                     run_in = pst_pkg::RUN_STOPPED;
                  end
                  pst_pkg::OP_TICK: begin
                     elapsed_in = q_cmd.now_ms - origin_ff;
                     n_in       = '0;
                  end
                  default: begin
                     run_in = run_ff;
                  end
               endcase
            end
         end
         pst_pkg::ST_INS_RD: begin
            mem_raddr = pos_m1[AW-1:0];
         end
         pst_pkg::ST_INS_CMP: begin
            mem_we = 1'b1;
            if (shift) begin
               mem_wdata = rd_data_ff;
               pos_in    = pos_m1;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         pst_pkg::ST_INS_PUT: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
         end
         pst_pkg::ST_TK_CMP: begin
            if (due && (!pend_valid_ff || slot_free)) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_act_in   = pend_act_ff;
                  rsp_last_in  = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_act_in   = rd_data_ff.action;
               next_in       = next_ff + CW'(1);
               n_in          = n_ff + NW'(1);
            end
         end
         pst_pkg::ST_TK_END: begin
            if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_act_in    = pend_act_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
               end
               if (next_ff >= count_ff) begin
                  next_in = '0;
                  if (run_ff == pst_pkg::RUN_FOREVER) begin
                     origin_in = origin_ff + per_ff;
                  end else begin
                     left_in = left_dec;
                     if (left_dec != 16'd0) begin
                        origin_in = origin_ff + per_ff;
                     end else begin
                        run_in = pst_pkg::RUN_STOPPED;
                     end
                  end
               end
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      per_ff     <= {16'd0, period_units} * {16'd0, time_base};
      pos_ff     <= pos_in;
      off_ff     <= off_in;
      id_ff      <= id_in;
      elapsed_ff <= elapsed_in;
      n_ff       <= n_in;
      pend_act_ff <= pend_act_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pst_pkg::ST_IDLE;
         run_ff        <= pst_pkg::RUN_STOPPED;
         count_ff      <= '0;
         next_ff       <= '0;
         origin_ff     <= 32'd0;
         left_ff       <= 16'd0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         run_ff        <= run_in;
         count_ff      <= count_in;
         next_ff       <= next_in;
         origin_ff     <= origin_in;
         left_ff       <= left_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired_action  = rsp_act_ff;
   assign rsp_last_fired    = rsp_last_ff;
   assign status.state      = state_ff;
   assign status.pend_valid = pend_valid_ff;

endmodule

// ===== rtl/periodic_schedule_table_core.sv =====
// ----------------------------------------------------------------------------
// Periodic schedule table core
// Sorted table of timed actions replayed once per period, with a front end
// that queues commands and a back end that walks the table memory.
// ----------------------------------------------------------------------------
// A front end takes one request transfer per cycle, while its queue is not
// full, into a two-entry command queue, and a back end executes the commands
// one at a time against a table memory with one write port and a registered
// read port. Start, stop and a tick while stopped are handled in the idle
// state. An insert is dropped when the table is full or its scaled offset is
// past the period; any other is written after every entry with a larger
// offset has moved up one slot to make room. A tick on a running table fires
// the due actions in table order, with a cap of 16 actions per tick, and ends
// on an entry that is not yet due or at the end of the table; each table read
// passes through the memory's read register before it is compared. The last
// fired action is held until the walk ends, and results leave through an
// output register, so the walk stalls only while a held result waits behind
// a full output register. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`include "periodic_schedule_table_core_assert.svh"

module periodic_schedule_table_core #(
   parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic [31:0]                          req_now_ms,
   input  logic [15:0]                          req_offset_units,
   input  logic [7:0]                           req_action_id,
   input  logic [15:0]                          req_repeat_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_fired_action,
   output logic                                 rsp_last_fired,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pst_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pst_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [15:0]              time_base_ff, time_base_in;
   logic [15:0]              period_units_ff, period_units_in;
   logic                     q_valid;
   logic                     q_pop;
   pst_pkg::cmd_type         q_cmd;
   pst_pkg::back_status_type back_status;

   assign csr_ready = 1'b1;

   always_comb begin
      time_base_in    = time_base_ff;
      period_units_in = period_units_ff;
      if (csr_valid) begin
         case (csr_index)
            pst_pkg::CSR_TIME_BASE:    time_base_in    = csr_wdata;
            pst_pkg::CSR_PERIOD_UNITS: period_units_in = csr_wdata;
            default: begin
               time_base_in = time_base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_base_ff    <= pst_pkg::TIME_BASE_RESET;
         period_units_ff <= pst_pkg::PERIOD_UNITS_RESET;
      end else begin
         time_base_ff    <= time_base_in;
         period_units_ff <= period_units_in;
      end
   end

   pst_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_now_ms       (req_now_ms),
      .req_offset_units (req_offset_units),
      .req_action_id    (req_action_id),
      .req_repeat_count (req_repeat_count),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_cmd            (q_cmd)
   );

   pst_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .time_base        (time_base_ff),
      .period_units     (period_units_ff),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_cmd            (q_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired_action (rsp_fired_action),
      .rsp_last_fired   (rsp_last_fired),
      .status           (back_status)
   );

   `PST_ASSERT_NEXT(a_accept_queued, clock, reset, req_valid && req_ready, q_valid, "accepted request not queued")
   `PST_ASSERT_IMPLY(a_idle_no_pending, clock, reset, back_status.state == pst_pkg::ST_IDLE, !back_status.pend_valid, "pending result left over in idle")
   `PST_ASSERT_IMPLY(a_result_from_tick, clock, reset, $rose(rsp_valid), $past(back_status.state) == pst_pkg::ST_TK_CMP || $past(back_status.state) == pst_pkg::ST_TK_END, "result outside a tick")

endmodule

// ===== tb/periodic_schedule_table_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the periodic schedule table core
// Drives insert, start, stop and tick commands through the request channel,
// loads the time base and period registers between phases, and checks every
// fired action against a cycle-free prediction of the sorted action table.
// ----------------------------------------------------------------------------

localparam int TABLE_SLOTS = pst_pkg::TABLE_DEPTH_DEFAULT;

typedef struct packed {
   logic [7:0] action;
   logic       last;
} fire_type;

class fire_board_type;
   logic [31:0]      slot_offset [TABLE_SLOTS];
   logic [7:0]       slot_action [TABLE_SLOTS];
   int unsigned      used;
   int unsigned      cursor;
   logic [31:0]      origin_ms;
   pst_pkg::run_type run_state;
   logic [15:0]      periods_left;
   logic [15:0]      time_base;
   logic [15:0]      period_units;
   fire_type         pending[$];
   int unsigned      errors;
   int unsigned      checked;

   function new();
      used = 0;
      cursor = 0;
      origin_ms = '0;
      run_state = pst_pkg::RUN_STOPPED;
      periods_left = '0;
      time_base = pst_pkg::TIME_BASE_RESET;
      period_units = pst_pkg::PERIOD_UNITS_RESET;
      errors = 0;
      checked = 0;
   endfunction

   function void set_register(logic [pst_pkg::CSR_INDEX_WIDTH-1:0] index, logic [15:0] data);
      case (index)
         pst_pkg::CSR_TIME_BASE:    time_base = data;
         pst_pkg::CSR_PERIOD_UNITS: period_units = data;
         default: ;
      endcase
   endfunction

   function logic [31:0] period_ms();
      return {16'd0, period_units} * {16'd0, time_base};
   endfunction

   function logic [31:0] span_ms();
      logic [31:0] p;
      p = period_ms();
      if (used != 0 && slot_offset[used-1] > p)
         return slot_offset[used-1];
      return p;
   endfunction

   function void note_command(pst_pkg::op_type op, logic [31:0] now_ms, logic [15:0] units,
                              logic [7:0] id, logic [15:0] reps);
      logic [31:0] scaled;
      logic [31:0] elapsed;
      int unsigned pos;
      logic [7:0]  burst[$];
      fire_type    rec;
      case (op)
         pst_pkg::OP_INSERT: begin
            scaled = {16'd0, units} * {16'd0, time_base};
            if (used < TABLE_SLOTS && scaled <= period_ms()) begin
               pos = used;
               while (pos > 0 && slot_offset[pos-1] > scaled) begin
                  slot_offset[pos] = slot_offset[pos-1];
                  slot_action[pos] = slot_action[pos-1];
                  pos--;
               end
               slot_offset[pos] = scaled;
               slot_action[pos] = id;
               used++;
            end
         end
         pst_pkg::OP_START: begin
            origin_ms = now_ms;
            cursor = 0;
            periods_left = reps;
            run_state = (reps != 0) ? pst_pkg::RUN_PERIODIC : pst_pkg::RUN_FOREVER;
         end
         pst_pkg::OP_STOP: run_state = pst_pkg::RUN_STOPPED;
         pst_pkg::OP_TICK: begin
            if (run_state != pst_pkg::RUN_STOPPED) begin
               elapsed = now_ms - origin_ms;
               burst = {};
               while (burst.size() < pst_pkg::MAX_RESULTS && cursor < used &&
                      elapsed >= slot_offset[cursor]) begin
                  burst.push_back(slot_action[cursor]);
                  cursor++;
               end
               for (int k = 0; k < burst.size(); k++) begin
                  rec.action = burst[k];
                  rec.last = (k == burst.size() - 1);
                  pending.push_back(rec);
               end
               if (cursor >= used) begin
                  cursor = 0;
                  if (run_state == pst_pkg::RUN_FOREVER) begin
                     origin_ms = origin_ms + period_ms();
                  end else begin
                     periods_left = periods_left - 16'd1;
                     if (periods_left != 0)
                        origin_ms = origin_ms + period_ms();
                     else
                        run_state = pst_pkg::RUN_STOPPED;
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function void check_fire(logic [7:0] action, logic last);
      fire_type want;
      checked++;
      if (pending.size() == 0) begin
         $display("%0t: unexpected transfer, fired_action %0d last_fired %0b",
                  $time, action, last);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (action !== want.action) begin
         $display("%0t: fired_action expected %0d got %0d", $time, want.action, action);
         errors++;
      end
      if (last !== want.last) begin
         $display("%0t: last_fired expected %0b got %0b", $time, want.last, last);
         errors++;
      end
   endfunction
endclass

module periodic_schedule_table_core_tb;

   localparam int          RUN_LIMIT       = 600000;
   localparam int          SETTLE_CYCLES   = 150;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          PHASES          = 12;
   localparam int          PHASE_ITEMS     = 30;
   localparam logic [pst_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED_TOP = 4'hF;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = pst_pkg::OP_INSERT;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_offset_units = '0;
   logic [7:0]  req_action_id = '0;
   logic [15:0] req_repeat_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_fired_action;
   logic        rsp_last_fired;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [pst_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [pst_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   fire_board_type board;
   int unsigned    cycle_count = 0;
   int unsigned    commands_sent = 0;
   int unsigned    hold_requests = 0;
   int             idle_pct = 0;
   bit             quiet = 1'b0;
   logic [31:0]    wall_ms = '0;

   periodic_schedule_table_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_now_ms       (req_now_ms),
      .req_offset_units (req_offset_units),
      .req_action_id    (req_action_id),
      .req_repeat_count (req_repeat_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_fired_action (rsp_fired_action),
      .rsp_last_fired   (rsp_last_fired),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("FAIL periodic_schedule_table_core");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_fire(rsp_fired_action, rsp_last_fired);
   end

   initial begin : receiver
      int unsigned holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_requests > holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_cmd(pst_pkg::op_type op, logic [31:0] now_ms, logic [15:0] units,
                           logic [7:0] id, logic [15:0] reps);
      if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= op;
      req_now_ms <= now_ms;
      req_offset_units <= units;
      req_action_id <= id;
      req_repeat_count <= reps;
      do @(posedge clock); while (!req_ready);
      board.note_command(op, now_ms, units, id, reps);
      commands_sent++;
   endtask

   task automatic write_csr(logic [pst_pkg::CSR_INDEX_WIDTH-1:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, data);
   endtask

   task automatic load_registers(logic [15:0] scale, logic [15:0] period, bit spare);
      write_csr(pst_pkg::CSR_TIME_BASE, scale);
      write_csr(pst_pkg::CSR_PERIOD_UNITS, period);
      if (spare)
         write_csr(pst_pkg::CSR_INDEX_WIDTH'($urandom_range(2, 15)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic start_table();
      logic [15:0] reps;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 2)
         reps = '0;
      else if (pick < 8)
         reps = 16'($urandom_range(1, 3));
      else
         reps = 16'($urandom);
      wall_ms = $urandom;
      send_cmd(pst_pkg::OP_START, wall_ms, 16'($urandom), 8'($urandom), reps);
   endtask

   task automatic tick_table();
      logic [31:0] span;
      span = board.span_ms();
      if ($urandom_range(0, 9) == 0)
         wall_ms = $urandom;
      else
         wall_ms = wall_ms + $urandom_range(0, span / 4 + 1);
      send_cmd(pst_pkg::OP_TICK, wall_ms, 16'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic directed_items();
      send_cmd(pst_pkg::OP_TICK, 32'd5, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_START, 32'd1000, 16'd0, 8'd0, 16'd2);
      send_cmd(pst_pkg::OP_TICK, 32'd1000, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_STOP, 32'd0, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_INSERT, 32'd0, 16'd0, 8'h00, 16'd0);
      send_cmd(pst_pkg::OP_INSERT, 32'd0, 16'd100, 8'hFF, 16'd0);
      send_cmd(pst_pkg::OP_INSERT, 32'd0, 16'd101, 8'h12, 16'd0);
      send_cmd(pst_pkg::OP_INSERT, 32'd0, 16'd50, 8'hA5, 16'd0);
      send_cmd(pst_pkg::OP_INSERT, 32'd0, 16'd50, 8'h5A, 16'd0);
      send_cmd(pst_pkg::OP_INSERT, 32'd0, 16'hFFFF, 8'h33, 16'd0);
      send_cmd(pst_pkg::OP_START, 32'hFFFF_FFC0, 16'd0, 8'd0, 16'd2);
      send_cmd(pst_pkg::OP_TICK, 32'hFFFF_FFC0, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_TICK, 32'hFFFF_FFF0, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_TICK, 32'h0000_0010, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_INSERT, 32'd0, 16'd20, 8'h77, 16'd0);
      send_cmd(pst_pkg::OP_TICK, 32'h0000_0030, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_STOP, 32'd0, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_TICK, 32'h0000_1000, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_START, 32'd0, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_TICK, 32'hFFFF_FFFF, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_TICK, 32'd150, 16'd0, 8'd0, 16'd0);
      send_cmd(pst_pkg::OP_STOP, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
      send_cmd(pst_pkg::OP_START, 32'h8000_0000, 16'd0, 8'd0, 16'hFFFF);
      send_cmd(pst_pkg::OP_TICK, 32'h8000_003C, 16'd0, 8'd0, 16'd0);
   endtask

   task automatic random_phase(int phase);
      logic [15:0]     scale;
      logic [15:0]     period;
      int              r;
      pst_pkg::op_type op;
      logic [31:0]     stamp;
      case (phase)
         0: begin
            scale = '0;
            period = 16'($urandom_range(0, 300));
         end
         1: begin
            scale = 16'hFFFF;
            period = 16'hFFFF;
         end
         2: begin
            scale = 16'd1;
            period = '0;
         end
         3: begin
            scale = 16'd1;
            period = 16'hFFFF;
         end
         default: begin
            if ($urandom_range(0, 3) == 0) begin
               scale = 16'($urandom_range(1, 65535));
               period = 16'($urandom);
            end else begin
               scale = 16'($urandom_range(1, 20));
               period = 16'($urandom_range(0, 400));
            end
         end
      endcase
      wait_drained();
      load_registers(scale, period, $urandom_range(0, 2) == 0);
      case ($urandom_range(0, 2))
         0: idle_pct = 0;
         1: idle_pct = 10;
         default: idle_pct = 35;
      endcase
      if (quiet)
         idle_pct = 0;
      if (phase == 5)
         hold_requests++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         r = $urandom_range(0, 99);
         if (board.run_state == pst_pkg::RUN_STOPPED && r < 85) begin
            start_table();
         end else if (r < 14 && board.used < TABLE_SLOTS) begin
            send_cmd(pst_pkg::OP_INSERT, $urandom, 16'($urandom_range(0, period)),
                     8'($urandom), 16'($urandom));
         end else if (r < 19) begin
            send_cmd(pst_pkg::OP_INSERT, $urandom, 16'($urandom), 8'($urandom),
                     16'($urandom));
         end else if (r < 24) begin
            op = pst_pkg::op_type'(2'($urandom_range(0, 3)));
            stamp = $urandom;
            if (op == pst_pkg::OP_START)
               wall_ms = stamp;
            send_cmd(op, stamp, 16'($urandom), 8'($urandom), 16'($urandom));
         end else if (r < 27) begin
            send_cmd(pst_pkg::OP_STOP, $urandom, 16'($urandom), 8'($urandom),
                     16'($urandom));
         end else if (r < 30) begin
            start_table();
         end else begin
            tick_table();
         end
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_csr(CSR_UNUSED_TOP, 16'hFFFF);
      load_registers(16'd1, 16'd100, 1'b0);
      directed_items();
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase >= PHASES - 2)
            quiet = 1'b1;
         random_phase(phase);
      end
      wait_drained();
      $display("Sent %0d commands over %0d register settings and checked %0d fired actions.",
               commands_sent, PHASES + 1, board.checked);
      $display("The table ended with %0d entries; %0d mismatches were seen.",
               board.used, board.errors);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASS periodic_schedule_table_core");
      else
         $display("FAIL periodic_schedule_table_core");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_front.sv
rtl/pst_back.sv
rtl/periodic_schedule_table_core.sv
tb/periodic_schedule_table_core_tb.sv
